// ===== hw/rtl/obbp_pkg.sv =====
package obbp_pkg;

  // Default book size and price width.
  localparam int unsigned DefaultDepth     = 64;
  localparam int unsigned DefaultPriceBits = 32;

  // Widths of the fixed port fields.
  localparam int unsigned InPriceW = 32;
  localparam int unsigned IdW      = 32;
  localparam int unsigned OutPriceW = 32;

  // Operation carried by an input transaction.
  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Status reported with every result transaction.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the input transaction and clear the scan results
    logic scan;    // read one slot and advance the scan address
    logic commit;  // update the book and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_addr;  // the scan address points at the last slot
    logic out_busy;   // the result register holds a transaction not yet taken
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/order_book_best_price_unit.sv =====
// An accepted transaction is scanned over every slot and its result registered
// at commit; a new one is taken only in S_IDLE. The scan reads one slot per cycle
// through the single read port of the price and id memories.
// A waiting result does not stall the scan of the next transaction.
// Reset empties the book at once by clearing the slot valid bits; no clearing pass.
module order_book_best_price_unit #(
  parameter int unsigned DEPTH      = obbp_pkg::DefaultDepth,
  parameter int unsigned PRICE_BITS = obbp_pkg::DefaultPriceBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [obbp_pkg::InPriceW-1:0]    order_price_i,
  input  logic [obbp_pkg::IdW-1:0]         order_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [obbp_pkg::OutPriceW-1:0]   best_price_o,
  output logic                             book_empty_o
);
  import obbp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer for the scan and commit of one transaction.
  obbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Book storage, scan compare and result register.
  obbp_datapath #(
    .DEPTH      (DEPTH),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .order_price_i (order_price_i),
    .order_id_i    (order_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .best_price_o  (best_price_o),
    .book_empty_o  (book_empty_o)
  );

endmodule

// ===== hw/rtl/obbp_ctrl.sv =====
module obbp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  obbp_pkg::ctrl_sts_t   sts_i,
  output obbp_pkg::ctrl_cmd_t   cmd_o
);
  import obbp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  // The book is only open to a new transaction between scans.
  assign in_ready_o = (state_q == S_IDLE);

  assign cmd_o.start  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.scan   = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_COMMIT) && !sts_i.out_busy;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.last_addr) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The flush cycle always follows the read of the last slot.
  a_flush_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> $past(sts_i.last_addr) && $past(cmd_o.scan))
    else $error("flush entered before the scan reached the last slot");

endmodule

// ===== hw/rtl/obbp_datapath.sv =====
module obbp_datapath #(
  parameter int unsigned DEPTH      = obbp_pkg::DefaultDepth,
  parameter int unsigned PRICE_BITS = obbp_pkg::DefaultPriceBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  obbp_pkg::ctrl_cmd_t              cmd_i,
  output obbp_pkg::ctrl_sts_t              sts_o,
  input  logic                             op_i,
  input  logic [obbp_pkg::InPriceW-1:0]    order_price_i,
  input  logic [obbp_pkg::IdW-1:0]         order_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [obbp_pkg::OutPriceW-1:0]   best_price_o,
  output logic                             book_empty_o
);
  import obbp_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Captured input transaction.
  op_e                   op_q;
  logic [PRICE_BITS-1:0] px_q;
  logic [IdW-1:0]        key_q;

  // Book storage: valid bits in flops, prices and ids in memories.
  logic [DEPTH-1:0]      valid_q;
  logic [PRICE_BITS-1:0] price_mem [DEPTH];
  logic [IdW-1:0]        id_mem    [DEPTH];

  // Scan address and the registered read stage.
  logic [IdxW-1:0]       addr_q;
  logic                  s1_vld_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic                  s1_vbit_q;
  logic [PRICE_BITS-1:0] price_rd_q;
  logic [IdW-1:0]        id_rd_q;

  // Scan results.
  logic                  found_q;
  logic [IdxW-1:0]       found_idx_q;
  logic                  free_found_q;
  logic [IdxW-1:0]       free_idx_q;
  logic                  any_q;
  logic [PRICE_BITS-1:0] best_q;

  // Result register.
  logic                  out_valid_q;
  status_e               status_q;
  logic [OutPriceW-1:0]  best_out_q;
  logic                  empty_q;

  // Commit decision.
  status_e               res_status;
  logic [PRICE_BITS-1:0] res_best;
  logic                  res_any;
  logic                  do_write;
  logic                  do_clear;

  // Slot compare for the data now in the read stage.
  logic                  id_match;
  logic                  include_slot;

  assign sts_o.last_addr = (addr_q == IdxW'(DEPTH - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // Capture the transaction; the price keeps only its low PRICE_BITS bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_e'(op_i);
      px_q  <= PRICE_BITS'(order_price_i);
      key_q <= order_id_i;
    end
  end

  // Scan address counter and read-stage tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.scan) begin
        addr_q <= addr_q + IdxW'(1);
      end
      s1_vld_q <= cmd_i.scan;
    end
  end

  // Memories: one write port at commit, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_write) begin
      price_mem[free_idx_q] <= px_q;
      id_mem[free_idx_q]    <= key_q;
    end
    if (cmd_i.scan) begin
      price_rd_q <= price_mem[addr_q];
      id_rd_q    <= id_mem[addr_q];
      s1_idx_q   <= addr_q;
      s1_vbit_q  <= valid_q[addr_q];
    end
  end

  // A removed order is left out of the maximum so that it reflects the
  // book after the transaction; ids are unique, so at most one slot matches.
  assign id_match     = s1_vbit_q && (id_rd_q == key_q);
  assign include_slot = s1_vbit_q && !((op_q == OP_REMOVE) && id_match);

  // Accumulate id match, first free slot and the running maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      any_q        <= 1'b0;
      best_q       <= '0;
    end else if (cmd_i.start) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      any_q        <= 1'b0;
    end else if (s1_vld_q) begin
      if (id_match && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= s1_idx_q;
      end
      if (!s1_vbit_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= s1_idx_q;
      end
      if (include_slot && (!any_q || (price_rd_q > best_q))) begin
        best_q <= price_rd_q;
      end
      if (include_slot) begin
        any_q <= 1'b1;
      end
    end
  end

  // Decide the outcome of the transaction from the scan results.
  always_comb begin
    res_status = ST_DONE;
    res_best   = best_q;
    res_any    = any_q;
    do_write   = 1'b0;
    do_clear   = 1'b0;
    if (op_q == OP_ADD) begin
      if (found_q) begin
        res_status = ST_DUP;
      end else if (!free_found_q) begin
        res_status = ST_FULL;
      end else begin
        do_write = 1'b1;
        res_any  = 1'b1;
        if (!any_q || (px_q > best_q)) res_best = px_q;
      end
    end else begin
      if (!found_q) begin
        res_status = ST_NOTFOUND;
      end else begin
        do_clear = 1'b1;
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (do_write) valid_q[free_idx_q] <= 1'b1;
      if (do_clear) valid_q[found_idx_q] <= 1'b0;
    end
  end

  // Result register: loaded at commit, held until the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= res_status;
      best_out_q <= res_any ? OutPriceW'(res_best) : '0;
      empty_q    <= !res_any;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign best_price_o = best_out_q;
  assign book_empty_o = empty_q;

  // A matching slot is valid and a free slot is not, so they never coincide.
  a_match_free_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && free_found_q) |-> (found_idx_q != free_idx_q))
    else $error("matching slot and free slot coincide");

  // A successful add marks its slot valid.
  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && do_write) |=> valid_q[$past(free_idx_q)])
    else $error("added order did not mark its slot valid");

  // After a successful add the book cannot be reported empty.
  a_add_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && do_write) |=> (out_valid_q && !empty_q))
    else $error("book reported empty after a successful add");

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// ===== sim/order_book_best_price_unit_tb.sv =====
`timescale 1ns / 1ps

module order_book_best_price_unit_tb;
  import obbp_pkg::*;

  localparam int unsigned Depth     = DefaultDepth;
  localparam int unsigned PriceBits = DefaultPriceBits;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int unsigned HangLimit = 4000;
  localparam logic [63:0] PriceMask = (64'd1 << PriceBits) - 64'd1;

  // One result as the block reports it.
  typedef struct packed {
    status_e     status;
    logic [31:0] best_price;
    logic        book_empty;
  } book_quote_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 op_i;
  logic [InPriceW-1:0]  order_price_i;
  logic [IdW-1:0]       order_id_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           status_o;
  logic [OutPriceW-1:0] best_price_o;
  logic                 book_empty_o;

  // Shadow copy of the resting orders.
  logic        book_valid [Depth];
  logic [31:0] book_price [Depth];
  logic [31:0] book_id    [Depth];
  int unsigned live_count;

  book_quote_t expected_quotes [$];
  int unsigned mismatch_count;
  int unsigned hang_cycles;
  int unsigned stall_left;
  logic        idle_enable;

  order_book_best_price_unit #(
    .DEPTH     (Depth),
    .PRICE_BITS(PriceBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .order_price_i(order_price_i),
    .order_id_i   (order_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .best_price_o (best_price_o),
    .book_empty_o (book_empty_o)
  );

  // Free-running clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one order to the shadow book and returns the quote it should produce.
  function automatic book_quote_t apply_order(op_e op, logic [31:0] price, logic [31:0] id);
    book_quote_t quote;
    int          hit;
    int          free_slot;
    logic [31:0] px;
    logic        any;
    hit       = -1;
    free_slot = -1;
    px        = price & PriceMask[31:0];
    for (int k = 0; k < Depth; k++) begin
      if (hit < 0 && book_valid[k] && book_id[k] == id) hit = k;
      if (free_slot < 0 && !book_valid[k]) free_slot = k;
    end
    quote.status = ST_DONE;
    if (op == OP_ADD) begin
      // The duplicate check wins over the full check.
      if (hit >= 0) begin
        quote.status = ST_DUP;
      end else if (free_slot < 0) begin
        quote.status = ST_FULL;
      end else begin
        book_valid[free_slot] = 1'b1;
        book_price[free_slot] = px;
        book_id[free_slot]    = id;
        live_count++;
      end
    end else begin
      if (hit < 0) begin
        quote.status = ST_NOTFOUND;
      end else begin
        book_valid[hit] = 1'b0;
        live_count--;
      end
    end
    // Highest resting price; zero with the empty flag when nothing rests.
    any              = 1'b0;
    quote.best_price = '0;
    for (int k = 0; k < Depth; k++) begin
      if (book_valid[k]) begin
        if (!any || book_price[k] > quote.best_price) quote.best_price = book_price[k];
        any = 1'b1;
      end
    end
    quote.book_empty = !any;
    return quote;
  endfunction

  // Returns the id of a randomly chosen resting order.
  function automatic logic [31:0] pick_live_id();
    int start;
    int idx;
    start = $urandom_range(0, Depth - 1);
    for (int k = 0; k < Depth; k++) begin
      idx = (start + k) % Depth;
      if (book_valid[idx]) return book_id[idx];
    end
    return '0;
  endfunction

  // Prices lean toward the extremes and a narrow band that produces ties.
  function automatic logic [31:0] draw_price();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      3: return 32'hffff_fff0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Drives one order transaction and records its expected quote on acceptance.
  task automatic send_order(input op_e op, input logic [31:0] price, input logic [31:0] id);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 6);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    op_i          = op;
    order_price_i = price;
    order_id_i    = id;
    do @(posedge clk_i); while (!in_ready_o);
    expected_quotes.push_back(apply_order(op, price, id));
  endtask

  // Random order flow; the weights steer the book toward full, empty or a mix.
  task automatic run_order_flow(input int unsigned count, input int unsigned w_add,
                                input int unsigned w_dup, input int unsigned w_rem,
                                input int unsigned w_miss);
    int unsigned roll;
    op_e         op;
    logic [31:0] id;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, w_add + w_dup + w_rem + w_miss - 1);
      if (roll < w_add) begin
        op = OP_ADD;
        id = $urandom;
      end else if (roll < w_add + w_dup) begin
        op = OP_ADD;
        id = (live_count > 0) ? pick_live_id() : $urandom;
      end else if (roll < w_add + w_dup + w_rem) begin
        op = OP_REMOVE;
        id = (live_count > 0) ? pick_live_id() : $urandom;
      end else begin
        op = OP_REMOVE;
        id = $urandom;
      end
      send_order(op, draw_price(), id);
    end
  endtask

  // Removes on an empty book find nothing, whatever the price field holds.
  task automatic test_empty_book();
    send_order(OP_REMOVE, '0, '0);
    send_order(OP_REMOVE, '1, '1);
  endtask

  // Extreme prices and ids; a zero price must still clear the empty flag.
  task automatic test_price_extremes();
    send_order(OP_ADD, '0, '0);
    send_order(OP_ADD, '1, '1);
    send_order(OP_ADD, 32'd1, 32'd1);
    send_order(OP_REMOVE, 32'h5555_aaaa, '1);
    send_order(OP_REMOVE, '0, 32'd1);
    send_order(OP_REMOVE, '1, '0);
  endtask

  // Duplicate id on add, unknown id on remove, and reuse of a freed id.
  task automatic test_duplicate_and_missing_id();
    send_order(OP_ADD, 32'd100, 32'd5);
    send_order(OP_ADD, 32'd200, 32'd5);
    send_order(OP_REMOVE, 32'd100, 32'd6);
    send_order(OP_REMOVE, '1, 32'd5);
    send_order(OP_ADD, 32'd300, 32'd5);
    send_order(OP_REMOVE, '0, 32'd5);
  endtask

  // Two orders at one price: removing one leaves that price on top.
  task automatic test_equal_prices();
    send_order(OP_ADD, 32'h8000_0000, 32'haaaa_5555);
    send_order(OP_ADD, 32'h8000_0000, 32'h5555_aaaa);
    send_order(OP_ADD, 32'h7fff_ffff, 32'd7);
    send_order(OP_REMOVE, '0, 32'haaaa_5555);
    send_order(OP_REMOVE, '0, 32'h5555_aaaa);
    send_order(OP_REMOVE, '0, 32'd7);
  endtask

  // Mostly adds: the book fills and then refuses further adds.
  task automatic test_fill_to_full();
    run_order_flow(130, 85, 5, 5, 5);
  endtask

  // Mostly removes: the book drains down to empty and stays there a while.
  task automatic test_drain_to_empty();
    run_order_flow(110, 10, 5, 75, 10);
  endtask

  task automatic test_mixed_traffic();
    run_order_flow(160, 40, 10, 40, 10);
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    run_order_flow(30, 45, 5, 45, 5);
  endtask

  // Result side: ready drops in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(1, 6) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Compares every accepted result transaction with the oldest expected quote.
  always @(posedge clk_i) begin : check_quote
    book_quote_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_quotes.size() == 0) begin
        $display("%0t: unexpected result: status %0d best_price %h book_empty %b",
                 $time, status_o, best_price_o, book_empty_o);
        mismatch_count++;
      end else begin
        want = expected_quotes.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (best_price_o !== want.best_price) begin
          $display("%0t: best_price expected %h actual %h", $time, want.best_price,
                   best_price_o);
          mismatch_count++;
        end
        if (book_empty_o !== want.book_empty) begin
          $display("%0t: book_empty expected %b actual %b", $time, want.book_empty,
                   book_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      hang_cycles = 0;
    end else begin
      hang_cycles++;
      if (hang_cycles >= HangLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, HangLimit);
        $display("order_book_best_price_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_ADD;
    order_price_i  = '0;
    order_id_i     = '0;
    out_ready_i    = 1'b0;
    idle_enable    = 1'b1;
    stall_left     = 0;
    hang_cycles    = 0;
    mismatch_count = 0;
    live_count     = 0;
    for (int k = 0; k < Depth; k++) begin
      book_valid[k] = 1'b0;
      book_price[k] = '0;
      book_id[k]    = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_book();
    test_price_extremes();
    test_duplicate_and_missing_id();
    test_equal_prices();
    test_fill_to_full();
    test_drain_to_empty();
    test_mixed_traffic();
    test_back_to_back();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    // Drain the outstanding results, then watch for strays over one more scan.
    while (expected_quotes.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("order_book_best_price_unit test passed");
    end else begin
      $display("order_book_best_price_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/obbp_pkg.sv
hw/rtl/obbp_ctrl.sv
hw/rtl/obbp_datapath.sv
hw/rtl/order_book_best_price_unit.sv
sim/order_book_best_price_unit_tb.sv
